### rtl/core/tcp_payload_extractor_top_defines.svh
// assertion macros used by the extractor queue
`ifndef TCP_PAYLOAD_EXTRACTOR_TOP_DEFINES_SVH
`define TCP_PAYLOAD_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPE_ASSERT(lbl, prop, msg)
`define TPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/tpe_pkg.sv
`default_nettype none

package tpe_pkg;

  localparam int IDX_W = 17;
  localparam int LEN_W = 18;
  localparam int HDR_W = 7;
  localparam int CFG_W = 16;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 96;

  localparam int DEFAULT_MAX_LENGTH_LIMIT = 65535;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [3:0] IP_V4 = 4'd4;
  localparam logic [3:0] IP_V6 = 4'd6;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [IDX_W-1:0] V4_PROTO_POS = 17'd9;
  localparam logic [IDX_W-1:0] V6_NEXT_POS = 17'd6;
  localparam logic [HDR_W-1:0] MIN_HDR = 7'd20;
  localparam logic [HDR_W-1:0] V6_HDR = 7'd40;
  localparam logic [HDR_W-1:0] OFFSET_POS = 7'd12;
  localparam logic [LEN_W-1:0] MIN_PACKET = 18'd40;
  localparam logic [IDX_W-1:0] INDEX_MAX = 17'h1FFFF;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    VERDICT_PAYLOAD   = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_NOT_IP    = 3'd2,
    VERDICT_NOT_TCP   = 3'd3,
    VERDICT_BAD_HDR   = 3'd4,
    VERDICT_EMPTY     = 3'd5,
    VERDICT_TOO_LONG  = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             in_payload;
    logic             last_byte;
    logic [LEN_W-1:0] length;
    logic             version_ok;
    logic             is_tcp;
    logic [HDR_W-1:0] hdr_bytes;
    logic             offset_known;
    logic [HDR_W-1:0] payload_start;
    logic [31:0]      capture_time;
  } tpe_entry_t;

endpackage

`default_nettype wire

### rtl/core/tpe_front.sv
`default_nettype none

module tpe_front import tpe_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // data_byte, capture_time
  input  wire logic                s_tlast,
  input  wire logic                q_full,
  output logic                     q_push,
  output tpe_entry_t               q_entry
);

  logic [IDX_W-1:0] byte_index;
  logic [3:0]       ip_version;
  logic [3:0]       ip_header_words;
  logic             is_tcp;
  logic [HDR_W-1:0] payload_start;
  logic             offset_known;
  logic [31:0]      latched_time;

  logic [7:0]       b;
  logic             first;
  logic [3:0]       ver_c;
  logic [3:0]       ihl_c;
  logic [31:0]      time_c;
  logic             tcp_c;
  logic [HDR_W-1:0] hdr_c;
  logic [HDR_W-1:0] ps_c;
  logic             ok_c;
  logic             inpay_c;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign b        = s_tdata[7:0];
  assign first    = (byte_index == '0);

  always_comb begin
    ver_c  = first ? b[7:4] : ip_version;
    ihl_c  = first ? b[3:0] : ip_header_words;
    time_c = first ? s_tdata[39:8] : latched_time;

    tcp_c = is_tcp;
    if ((ver_c == IP_V4 && byte_index == V4_PROTO_POS) ||
        (ver_c == IP_V6 && byte_index == V6_NEXT_POS)) begin
      tcp_c = (b == PROTO_TCP);
    end

    hdr_c = '0;
    if (ver_c == IP_V4) begin
      hdr_c = {1'b0, ihl_c, 2'b00};
      if (hdr_c < MIN_HDR) begin
        hdr_c = '0;
      end
    end else if (ver_c == IP_V6) begin
      hdr_c = V6_HDR;
    end

    ps_c = payload_start;
    ok_c = offset_known;
    if (hdr_c != '0 && byte_index == IDX_W'(hdr_c) + IDX_W'(OFFSET_POS)) begin
      ps_c = hdr_c + {1'b0, b[7:4], 2'b00};
      ok_c = 1'b1;
    end

    inpay_c = ok_c && tcp_c && (byte_index >= IDX_W'(ps_c));
  end

  always_comb begin
    q_entry.data_byte     = b;
    q_entry.in_payload    = inpay_c;
    q_entry.last_byte     = s_tlast;
    q_entry.length        = LEN_W'(byte_index) + LEN_W'(1);
    q_entry.version_ok    = (ver_c == IP_V4) || (ver_c == IP_V6);
    q_entry.is_tcp        = tcp_c;
    q_entry.hdr_bytes     = hdr_c;
    q_entry.offset_known  = ok_c;
    q_entry.payload_start = ps_c;
    q_entry.capture_time  = time_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      ip_version      <= '0;
      ip_header_words <= '0;
      is_tcp          <= 1'b0;
      payload_start   <= '0;
      offset_known    <= 1'b0;
      latched_time    <= '0;
    end else if (q_push) begin
      latched_time <= time_c;
      if (s_tlast) begin
        byte_index      <= '0;
        ip_version      <= '0;
        ip_header_words <= '0;
        is_tcp          <= 1'b0;
        payload_start   <= '0;
        offset_known    <= 1'b0;
      end else begin
        byte_index      <= (byte_index < INDEX_MAX) ? byte_index + IDX_W'(1) : INDEX_MAX;
        ip_version      <= ver_c;
        ip_header_words <= ihl_c;
        is_tcp          <= tcp_c;
        payload_start   <= ps_c;
        offset_known    <= ok_c;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/tpe_queue.sv
`default_nettype none

`include "tcp_payload_extractor_top_defines.svh"

module tpe_queue import tpe_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire tpe_entry_t wr_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output tpe_entry_t      rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tpe_entry_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `TPE_ASSERT(a_no_overflow, push |-> !full, "request written into a full queue")
  `TPE_ASSERT(a_no_underflow, pop |-> not_empty, "request taken from an empty queue")
  `TPE_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + CNT_W'(1), "queue count lost a write")
  `TPE_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule

`default_nettype wire

### rtl/core/tpe_back.sv
`default_nettype none

module tpe_back import tpe_pkg::*; #(
  parameter int MAX_LENGTH_LIMIT = DEFAULT_MAX_LENGTH_LIMIT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                q_valid,
  input  wire tpe_entry_t          q_entry,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,
  output logic                     m_tlast,
  output logic                     m_tuser
);

  logic [CFG_W-1:0] max_packet_length;
  logic [31:0]      packet_counter;

  logic [7:0]       byte_out;
  logic             in_payload;
  logic             end_of_packet;
  verdict_t         verdict;
  logic [15:0]      payload_length;
  logic [31:0]      packet_number;
  logic [31:0]      time_out;

  logic [CFG_W-1:0] limit;
  logic             too_long;
  logic             hdr_bad;
  verdict_t         verdict_next;
  logic [15:0]      payload_length_next;
  logic [LEN_W-1:0] len;

  assign q_pop = q_valid && (!m_tvalid || m_tready);
  assign len   = q_entry.length;

  always_comb begin
    limit = (max_packet_length > CFG_W'(MAX_LENGTH_LIMIT)) ?
            CFG_W'(MAX_LENGTH_LIMIT) : max_packet_length;
    too_long = len > LEN_W'(limit);
    hdr_bad  = (q_entry.hdr_bytes == '0) ||
               (LEN_W'(q_entry.hdr_bytes) > len) ||
               (LEN_W'(q_entry.hdr_bytes) + LEN_W'(MIN_HDR) > len) ||
               !q_entry.offset_known ||
               (LEN_W'(q_entry.payload_start) > len);

    verdict_next        = VERDICT_PAYLOAD;
    payload_length_next = '0;
    if (q_entry.last_byte) begin
      priority if (len < MIN_PACKET) begin
        verdict_next = VERDICT_SHORT;
      end else if (!q_entry.version_ok) begin
        verdict_next = VERDICT_NOT_IP;
      end else if (!q_entry.is_tcp) begin
        verdict_next = VERDICT_NOT_TCP;
      end else if (hdr_bad) begin
        verdict_next = VERDICT_BAD_HDR;
      end else if (LEN_W'(q_entry.payload_start) == len) begin
        verdict_next = VERDICT_EMPTY;
      end else if (too_long) begin
        verdict_next = VERDICT_TOO_LONG;
      end else begin
        verdict_next        = VERDICT_PAYLOAD;
        payload_length_next = 16'(len - LEN_W'(q_entry.payload_start));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_packet_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid       <= 1'b0;
      packet_counter <= '0;
    end else begin
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop && q_entry.last_byte && !too_long) begin
        packet_counter <= packet_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_out       <= q_entry.data_byte;
      in_payload     <= q_entry.in_payload;
      end_of_packet  <= q_entry.last_byte;
      verdict        <= verdict_next;
      payload_length <= payload_length_next;
      packet_number  <= packet_counter;
      time_out       <= q_entry.capture_time;
    end
  end

  assign m_tdata = {5'd0, time_out, packet_number, payload_length, verdict, byte_out};
  assign m_tlast = end_of_packet;
  assign m_tuser = in_payload;

endmodule

`default_nettype wire

### rtl/core/tcp_payload_extractor_top.sv
// Extracts the TCP payload position from raw IPv4 / IPv6 packets, one byte per request.
// Input stream s_*: one packet byte per request, tlast on the final byte; the capture
// timestamp in tdata is sampled on the first byte of each packet.
// Output stream m_*: one request per input byte, in order. tuser flags bytes at or past
// the TCP payload start; tlast marks the last byte, which carries the verdict, the payload
// length and the packet number. Bytes before the last carry verdict and length of zero.
// Config: cfg_we writes cfg_wdata into the maximum packet length (reset 65535); the limit
// in force is the smaller of that and MAX_LENGTH_LIMIT. Write only while idle.
// Throughput: one byte per cycle sustained while the receiver keeps m_tready high. Each
// accepted byte goes from the front classifier into the short queue, then through the
// verdict stage into the output register.
// The front keeps accepting while the queue has room, so a stalled receiver is absorbed by
// QUEUE_DEPTH entries plus the output register before s_tready drops; nothing is lost.
// Reset (rst, synchronous) empties the queue and output, clears the per-packet state and the
// packet counter, and restores the length register to 65535.
`default_nettype none

module tcp_payload_extractor_top import tpe_pkg::*; #(
  parameter int MAX_LENGTH_LIMIT = DEFAULT_MAX_LENGTH_LIMIT,
  parameter int QUEUE_DEPTH      = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // data_byte, capture_time
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // byte_out, verdict, payload_length,
                                              // packet_number, time_out, zero fill
  output logic                     m_tlast,
  output logic                     m_tuser    // in_payload
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  tpe_entry_t wr_entry;
  tpe_entry_t rd_entry;

  tpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (wr_entry)
  );

  tpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (wr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_entry  (rd_entry)
  );

  tpe_back #(
    .MAX_LENGTH_LIMIT (MAX_LENGTH_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (rd_entry),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

### tb/tcp_payload_extractor_top_tb.sv
`timescale 1ns / 100ps

module tcp_payload_extractor_top_tb;
  import tpe_pkg::*;

  typedef struct {
    logic [7:0]  byte_out;
    logic        in_payload;
    logic        eop;
    verdict_t    verdict;
    logic [15:0] pay_len;
    logic [31:0] pkt_num;
    logic [31:0] stamp;
  } extract_t;

  typedef struct {
    int       lim;
    int       ver;
    int       ihl;
    int       proto;
    int       doff;
    int       len;
    bit       calm;
    bit       typed;
    verdict_t verdict;
    int       pay_len;
  } packet_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  extract_t    pending_beats[$];
  int          mismatches = 0;
  int          sent_bytes = 0;
  int          sidle_pct = 15;
  int          ridle_pct = 15;
  bit          hold_req = 1'b0;

  // predictor state
  int unsigned pos_idx = 0;
  logic [3:0]  cur_ver = '0;
  logic [3:0]  cur_ihl = '0;
  bit          cur_tcp = 1'b0;
  int          pay_start = 0;
  bit          doff_seen = 1'b0;
  logic [31:0] pkt_count = '0;
  logic [31:0] first_time = '0;
  logic [15:0] len_limit = MAX_LEN_RESET;

  packet_row_t dir_rows [20] = '{
    '{0, 4, 5, 6, 5, 1, 0, 1, VERDICT_SHORT, 0},
    '{0, 4, 5, 6, 5, 39, 0, 1, VERDICT_SHORT, 0},
    '{0, 5, 5, 6, 5, 40, 0, 1, VERDICT_NOT_IP, 0},
    '{0, 0, 0, 0, 0, 40, 0, 1, VERDICT_NOT_IP, 0},
    '{0, 15, 15, 255, 15, 64, 0, 1, VERDICT_NOT_IP, 0},
    '{0, 4, 5, 17, 5, 60, 0, 1, VERDICT_NOT_TCP, 0},
    '{0, 6, 0, 17, 5, 100, 0, 1, VERDICT_NOT_TCP, 0},
    '{0, 4, 4, 6, 5, 60, 0, 1, VERDICT_BAD_HDR, 0},
    '{0, 4, 15, 6, 5, 70, 0, 1, VERDICT_BAD_HDR, 0},
    '{0, 4, 5, 6, 15, 60, 0, 1, VERDICT_BAD_HDR, 0},
    '{0, 4, 5, 6, 5, 40, 0, 1, VERDICT_EMPTY, 0},
    '{0, 4, 5, 6, 5, 41, 0, 1, VERDICT_PAYLOAD, 1},
    '{0, 4, 5, 6, 0, 40, 0, 1, VERDICT_PAYLOAD, 20},
    '{0, 6, 15, 6, 5, 100, 0, 1, VERDICT_PAYLOAD, 40},
    '{0, 6, 0, 6, 8, 80, 0, 0, VERDICT_PAYLOAD, 0},
    '{0, 4, 15, 6, 15, 125, 1, 1, VERDICT_PAYLOAD, 5},
    '{40, 4, 5, 6, 5, 41, 0, 1, VERDICT_TOO_LONG, 0},
    '{0, 4, 5, 6, 0, 40, 0, 1, VERDICT_PAYLOAD, 20},
    '{0, 4, 7, 6, 3, 45, 0, 0, VERDICT_PAYLOAD, 0},
    '{0, 4, 5, 6, 5, 33, 0, 1, VERDICT_SHORT, 0}
  };

  tcp_payload_extractor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic extract_t classify_byte(input logic [7:0] b, input bit last,
                                             input logic [31:0] t);
    extract_t r;
    int       hdr;
    int       len;
    if (pos_idx == 0) begin
      first_time = t;
      cur_ver    = b[7:4];
      cur_ihl    = b[3:0];
    end
    if (cur_ver == IP_V4 && pos_idx == V4_PROTO_POS) cur_tcp = (b == PROTO_TCP);
    if (cur_ver == IP_V6 && pos_idx == V6_NEXT_POS) cur_tcp = (b == PROTO_TCP);
    hdr = 0;
    if (cur_ver == IP_V4 && int'(cur_ihl) * 4 >= int'(MIN_HDR)) hdr = int'(cur_ihl) * 4;
    else if (cur_ver == IP_V6) hdr = int'(V6_HDR);
    if (hdr != 0 && pos_idx == hdr + int'(OFFSET_POS)) begin
      pay_start = hdr + int'(b[7:4]) * 4;
      doff_seen = 1'b1;
    end
    r.byte_out   = b;
    r.in_payload = doff_seen && cur_tcp && (int'(pos_idx) >= pay_start);
    r.eop        = last;
    r.pkt_num    = pkt_count;
    r.stamp      = first_time;
    r.verdict    = VERDICT_PAYLOAD;
    r.pay_len    = '0;
    if (last) begin
      len = int'(pos_idx) + 1;
      if (len < int'(MIN_PACKET)) r.verdict = VERDICT_SHORT;
      else if (cur_ver != IP_V4 && cur_ver != IP_V6) r.verdict = VERDICT_NOT_IP;
      else if (!cur_tcp) r.verdict = VERDICT_NOT_TCP;
      else if (hdr == 0 || hdr > len || hdr + int'(MIN_HDR) > len || !doff_seen ||
               pay_start > len) r.verdict = VERDICT_BAD_HDR;
      else if (pay_start == len) r.verdict = VERDICT_EMPTY;
      else if (len > int'(len_limit)) r.verdict = VERDICT_TOO_LONG;
      else r.pay_len = 16'(len - pay_start);
      // over-long packets do not take a number
      if (len <= int'(len_limit)) pkt_count = pkt_count + 1;
      pos_idx   = 0;
      cur_ver   = '0;
      cur_ihl   = '0;
      cur_tcp   = 1'b0;
      pay_start = 0;
      doff_seen = 1'b0;
    end else if (pos_idx < INDEX_MAX) begin
      pos_idx = pos_idx + 1;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input verdict_t ev, input int eplen);
    logic [31:0] t;
    extract_t    r;
    t = $urandom;
    s_tvalid <= 1'b1;
    s_tdata  <= {t, b};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = classify_byte(b, last, t);
    if (last && typed) begin
      r.verdict = ev;
      r.pay_len = 16'(eplen);
    end
    pending_beats.insert(pending_beats.size(), r);
    sent_bytes++;
    if (sidle_pct > 0 && $urandom_range(0, 99) < sidle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_packet(input int ver, input int ihl, input int proto, input int doff,
                             input int len, input bit typed, input verdict_t ev,
                             input int eplen);
    int         doff_pos;
    logic [7:0] b;
    doff_pos = -1;
    if (ver == 4 && ihl * 4 >= 20) doff_pos = ihl * 4 + 12;
    else if (ver == 6) doff_pos = 52;
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom);
      if (k == 0) b = {4'(ver), 4'(ihl)};
      else if ((ver == 4 && k == 9) || (ver == 6 && k == 6)) b = 8'(proto);
      else if (k == doff_pos) b = {4'(doff), b[3:0]};
      send_byte(b, k == len - 1, typed, ev, eplen);
    end
  endtask

  task automatic send_random_packet();
    int ver;
    int ihl;
    int proto;
    int doff;
    int hdr;
    int ps;
    int len;
    int pick;
    pick = $urandom_range(0, 99);
    ver = (pick < 45) ? 4 : (pick < 85) ? 6 : $urandom_range(0, 15);
    ihl = (ver == 4 && $urandom_range(0, 99) < 80) ? 5 : $urandom_range(0, 15);
    proto = ($urandom_range(0, 99) < 85) ? 6 : $urandom_range(0, 255);
    doff = ($urandom_range(0, 99) < 70) ? $urandom_range(5, 8) : $urandom_range(0, 15);
    hdr = (ver == 6) ? 40 : (ver == 4 && ihl >= 5) ? ihl * 4 : 20;
    ps = hdr + doff * 4;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = $urandom_range(1, 39);
    else if (pick < 20) len = ps;
    else if (pick < 30) len = hdr + $urandom_range(0, 20);
    else if (pick < 90) len = ps + $urandom_range(1, 60);
    else len = $urandom_range(161, 600);
    send_packet(ver, ihl, proto, doff, len, 1'b0, VERDICT_PAYLOAD, 0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_length_limit(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_limit = v;
  endtask

  function automatic void check_field(input string what, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // receiver side
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (ridle_pct > 0 && $urandom_range(0, 99) < ridle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    extract_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected request, expected none, actual %0h", $time, m_tdata);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("byte_out", want.byte_out, m_tdata[7:0]);
        check_field("in_payload", want.in_payload, m_tuser);
        check_field("end_of_packet", want.eop, m_tlast);
        check_field("verdict", want.verdict, m_tdata[10:8]);
        check_field("payload_length", want.pay_len, m_tdata[26:11]);
        check_field("packet_number", want.pkt_num, m_tdata[58:27]);
        check_field("time_out", want.stamp, m_tdata[90:59]);
      end
    end
  end

  initial begin
    int lim;
    int start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].lim != 0) set_length_limit(16'(dir_rows[i].lim));
      sidle_pct = dir_rows[i].calm ? 0 : 15;
      ridle_pct = dir_rows[i].calm ? 0 : 15;
      send_packet(dir_rows[i].ver, dir_rows[i].ihl, dir_rows[i].proto, dir_rows[i].doff,
                  dir_rows[i].len, dir_rows[i].typed, dir_rows[i].verdict,
                  dir_rows[i].pay_len);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 5:    lim = MAX_LEN_RESET;
        1:       lim = MIN_PACKET;
        3:       lim = $urandom_range(40, 65535);
        default: lim = $urandom_range(40, 200);
      endcase
      set_length_limit(16'(lim));
      sidle_pct = (ph == 5) ? 0 : $urandom_range(0, 30);
      ridle_pct = (ph == 5) ? 0 : $urandom_range(0, 30);
      // long receiver hold while the sender keeps going
      if (ph == 0) hold_req = 1'b1;
      start = sent_bytes;
      while (sent_bytes - start < 60) begin
        send_random_packet();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tpe_pkg.sv
rtl/core/tpe_front.sv
rtl/core/tpe_queue.sv
rtl/core/tpe_back.sv
rtl/core/tcp_payload_extractor_top.sv
tb/tcp_payload_extractor_top_tb.sv
